@@ hdl/rsch_pkg.sv @@
// Package for the ray/sphere closest-hit block: widths, opcodes, sequencer states
// and the row control struct type, plus a saturation function. No dependencies.
package rsch_pkg;

   localparam int DefMaxSpheres = 64;
   localparam int DefCoordBits  = 32;
   localparam int CountW        = 7;
   localparam int SlotW         = 6;
   localparam int RadW          = 31;
   localparam int ValW          = 32;
   localparam int ProdW         = 72;   // exact dot products of 33-bit terms
   localparam int DiscW         = 148;  // b^2 - 4ac
   localparam int RootW         = 74;   // floor(sqrt(disc))
   localparam int NumW          = 96;   // (-b +/- s) * 2^16
   localparam int DenW          = 74;   // 2a
   localparam int QuoW          = 34;   // quotient bits kept before saturation
   localparam int MulW          = 36;   // width of one shared multiplier operand

   localparam logic OpLoad = 1'b0;
   localparam logic OpCast = 1'b1;

   localparam logic [1:0] CsrCount = 2'd0;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_READ,
      SEQ_DOTS,
      SEQ_DISC,
      SEQ_SQRT,
      SEQ_DIV1,
      SEQ_DIV2,
      SEQ_NEXT,
      SEQ_DONE
   } seq_state_type;

   // Control from the sequencer to the bit-serial cell row.
   typedef struct packed {
      logic load;    // load a new operand set into the row
      logic shift;   // advance the row by one or two bit positions
   } row_ctrl_type;

   // Saturate a signed wide value to the signed 32-bit range.
   function automatic logic [ValW-1:0] sat32(input logic signed [QuoW:0] v);
      logic signed [QuoW:0] hi;
      logic signed [QuoW:0] lo;
      hi = (QuoW+1)'(32'sh7fffffff);
      lo = -(QuoW+1)'(33'sh080000000);
      if (v > hi) begin
         return 32'h7fffffff;
      end else if (v < lo) begin
         return 32'h80000000;
      end
      return v[ValW-1:0];
   endfunction

endpackage

@@ hdl/rsch_cell.sv @@
// One cell of the restoring subtract row: one radix-2 digit of a shared
// remainder. Depends on rsch_pkg.
module rsch_cell (
   input  logic clock,
   input  logic reset,
   input  rsch_pkg::row_ctrl_type ctrl,
   input  logic rem_bit_in,     // bit shifted in from the lower neighbour
   input  logic init_bit,
   input  logic sub_bit,        // bit of the subtrahend at this position
   input  logic borrow_in,
   input  logic take,           // commit the subtraction this cycle
   output logic rem_bit,
   output logic diff_bit,
   output logic borrow_out
);
   import rsch_pkg::*;

   logic rem_ff;
   logic rem_in;

   // Trial subtraction of the subtrahend from the shifted remainder.
   assign diff_bit   = rem_bit_in ^ sub_bit ^ borrow_in;
   assign borrow_out = (~rem_bit_in & (sub_bit | borrow_in)) | (sub_bit & borrow_in);
   assign rem_bit    = rem_ff;

   always_comb begin
      rem_in = rem_ff;
      if (ctrl.load) begin
         rem_in = init_bit;
      end else if (ctrl.shift) begin
         rem_in = take ? diff_bit : rem_bit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 1'b0;
      end else begin
         rem_ff <= rem_in;
      end
   end

endmodule

@@ hdl/rsch_row.sv @@
// Row of rsch_cell: a shift-and-subtract unit for the square root and divide.
// Depends on rsch_pkg and rsch_cell.
module rsch_row #(
   parameter int W = 160
) (
   input  logic clock,
   input  logic reset,
   input  rsch_pkg::row_ctrl_type ctrl,
   input  logic [W-1:0] init,
   input  logic [1:0]   feed,       // bottom bits: both (sqrt), feed[1] (divide)
   input  logic         two_bits,   // shift by two (square root) or one (divide)
   input  logic [W-1:0] sub,
   output logic [W-1:0] rem,
   output logic         fits
);
   import rsch_pkg::*;

   logic [W-1:0] shifted;
   logic [W-1:0] diff;
   logic [W:0]   borrow;

   // Shift in one or two bits at the low end; the cells hold the remainder.
   assign shifted = two_bits ? {rem[W-3:0], feed} : {rem[W-2:0], feed[1]};
   assign borrow[0] = 1'b0;
   assign fits = ~borrow[W];

   for (genvar i = 0; i < W; i++) begin : g_cell
      rsch_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .rem_bit_in (shifted[i]),
         .init_bit   (init[i]),
         .sub_bit    (sub[i]),
         .borrow_in  (borrow[i]),
         .take       (~borrow[W]),
         .rem_bit    (rem[i]),
         .diff_bit   (diff[i]),
         .borrow_out (borrow[i+1])
      );
   end

endmodule

@@ hdl/ray_sphere_closest_hit.sv @@
// Top level of the ray/sphere closest-hit block: sphere table, dot products,
// sequencer and closest-root tracking. Depends on rsch_pkg and rsch_row.
//
//  channel  | handshake            | payload
//  req_     | start / busy         | operation, slot, point, dir, radius, window
//  rsp_     | rsp_valid (1 cycle)  | hit, distance, sphere_index
//  csr_     | APB psel/penable     | sphere_count at address 0
//
// A load is taken in its accepting cycle and never raises busy. A cast holds busy
// while it searches n spheres, each through read, dots, discriminant, square root,
// two divides and next; a sphere with a negative discriminant skips the square
// root and divides, and a zero direction ends the cast after the dot products.
// Reset clears control state and sphere_count; the sphere table is undefined
// until loaded. The receiver cannot stall: rsp_valid is high for one cycle.
module ray_sphere_closest_hit #(
   parameter int MAX_SPHERES = rsch_pkg::DefMaxSpheres,
   parameter int COORD_BITS  = rsch_pkg::DefCoordBits
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic req_operation,
   input  logic [rsch_pkg::SlotW-1:0] req_sphere_slot,
   input  logic signed [rsch_pkg::ValW-1:0] req_point_x,
   input  logic signed [rsch_pkg::ValW-1:0] req_point_y,
   input  logic signed [rsch_pkg::ValW-1:0] req_point_z,
   input  logic signed [rsch_pkg::ValW-1:0] req_dir_x,
   input  logic signed [rsch_pkg::ValW-1:0] req_dir_y,
   input  logic signed [rsch_pkg::ValW-1:0] req_dir_z,
   input  logic [rsch_pkg::RadW-1:0] req_sphere_radius_in,
   input  logic signed [rsch_pkg::ValW-1:0] req_window_low,
   input  logic signed [rsch_pkg::ValW-1:0] req_window_high,
   output logic rsp_valid,
   output logic rsp_hit,
   output logic signed [rsch_pkg::ValW-1:0] rsp_distance,
   output logic [rsch_pkg::SlotW-1:0] rsp_sphere_index,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   import rsch_pkg::*;

   localparam int IdxW  = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
   localparam int CW    = (COORD_BITS < 32) ? COORD_BITS : 32;
   localparam int RowW  = 160;
   localparam int SqSteps  = RootW;
   localparam int DivSteps = NumW + 1;
   localparam int StepW = 8;
   localparam logic signed [QuoW:0] SatHi = (QuoW+1)'((64'sd1 <<< (CW - 1)) - 64'sd1);
   localparam logic signed [QuoW:0] SatLo = ~SatHi;

   // ---------------------------------------------------------------- csr
   logic [CountW-1:0] count_ff, count_in;
   assign pready = 1'b1;
   assign prdata = (paddr == CsrCount) ? {{(32-CountW){1'b0}}, count_ff} : 32'd0;
   always_comb begin
      count_in = count_ff;
      if (psel && penable && pwrite && paddr == CsrCount) begin
         count_in = pwdata[CountW-1:0];
      end
   end

   function automatic logic signed [ValW:0] sx(input logic [ValW-1:0] v);
      logic [ValW-1:0] m;
      m = v << (ValW - CW);
      return (ValW+1)'($signed(m) >>> (ValW - CW));
   endfunction

   // ---------------------------------------------------------------- table
   logic [ValW-1:0] mem_cx [MAX_SPHERES];
   logic [ValW-1:0] mem_cy [MAX_SPHERES];
   logic [ValW-1:0] mem_cz [MAX_SPHERES];
   logic [ValW-1:0] mem_r  [MAX_SPHERES];
   logic [ValW-1:0] rd_cx_ff, rd_cy_ff, rd_cz_ff, rd_r_ff;
   logic [IdxW:0]   slot_ff, slot_in;
   logic accept;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (accept && req_operation == OpLoad && 32'(req_sphere_slot) < MAX_SPHERES) begin
         mem_cx[req_sphere_slot[IdxW-1:0]] <= req_point_x;
         mem_cy[req_sphere_slot[IdxW-1:0]] <= req_point_y;
         mem_cz[req_sphere_slot[IdxW-1:0]] <= req_point_z;
         mem_r[req_sphere_slot[IdxW-1:0]]  <= {1'b0, req_sphere_radius_in};
      end
      rd_cx_ff <= mem_cx[slot_ff[IdxW-1:0]];
      rd_cy_ff <= mem_cy[slot_ff[IdxW-1:0]];
      rd_cz_ff <= mem_cz[slot_ff[IdxW-1:0]];
      rd_r_ff  <= mem_r[slot_ff[IdxW-1:0]];
   end

   // ---------------------------------------------------------------- ray regs
   logic signed [ValW:0] ox_ff, oy_ff, oz_ff, dx_ff, dy_ff, dz_ff, lo_ff, hi_ff;
   logic [IdxW:0] limit_ff;
   always_ff @(posedge clock) begin
      if (accept && req_operation == OpCast) begin
         ox_ff <= sx(req_point_x);
         oy_ff <= sx(req_point_y);
         oz_ff <= sx(req_point_z);
         dx_ff <= sx(req_dir_x);
         dy_ff <= sx(req_dir_y);
         dz_ff <= sx(req_dir_z);
         lo_ff <= sx(req_window_low);
         hi_ff <= sx(req_window_high);
         limit_ff <= (32'(count_ff) < MAX_SPHERES) ? (IdxW+1)'(count_ff)
                                                   : (IdxW+1)'(MAX_SPHERES);
      end
   end

   // ---------------------------------------------------------------- sequencer
   seq_state_type state_ff, state_in;
   logic [StepW-1:0] step_ff, step_in;
   logic [3:0] mstep_ff;

   // Shared 36x36 multiplier, one product a cycle, accumulated.
   logic signed [MulW-1:0] ma, mb;
   logic signed [2*MulW-1:0] prod_ff;
   logic signed [ValW:0] cox, coy, coz;
   logic signed [ProdW-1:0] a_ff, b_ff, c_ff;
   logic signed [DiscW-1:0] disc_ff;
   assign cox = ox_ff - sx(rd_cx_ff);
   assign coy = oy_ff - sx(rd_cy_ff);
   assign coz = oz_ff - sx(rd_cz_ff);

   // Wide products for the discriminant are split into 36-bit limbs over steps.
   logic signed [ProdW:0] bb;
   logic signed [ProdW+2:0] c4;
   assign bb = {b_ff, 1'b0};
   assign c4 = {c_ff[ProdW-1], c_ff, 2'b00};

   always_comb begin
      ma = '0;
      mb = '0;
      case (mstep_ff)
         4'd0: begin ma = MulW'(dx_ff); mb = MulW'(dx_ff); end
         4'd1: begin ma = MulW'(dy_ff); mb = MulW'(dy_ff); end
         4'd2: begin ma = MulW'(dz_ff); mb = MulW'(dz_ff); end
         4'd3: begin ma = MulW'(cox); mb = MulW'(dx_ff); end
         4'd4: begin ma = MulW'(coy); mb = MulW'(dy_ff); end
         4'd5: begin ma = MulW'(coz); mb = MulW'(dz_ff); end
         4'd6: begin ma = MulW'(cox); mb = MulW'(cox); end
         4'd7: begin ma = MulW'(coy); mb = MulW'(coy); end
         4'd8: begin ma = MulW'(coz); mb = MulW'(coz); end
         4'd9: begin ma = MulW'({1'b0, rd_r_ff}); mb = MulW'({1'b0, rd_r_ff}); end
         default: begin ma = '0; mb = '0; end
      endcase
   end

   // Discriminant limbs: b^2 and 4ac from signed-magnitude 36-bit pieces.
   logic [ProdW:0] babs;
   logic [ProdW+2:0] cabs;
   logic [ProdW-1:0] aabs;
   logic dneg;
   assign babs = bb[ProdW] ? (ProdW+1)'(0) - bb : bb;
   assign aabs = a_ff;
   assign cabs = c4[ProdW+2] ? (ProdW+3)'(0) - c4 : c4;
   assign dneg = c4[ProdW+2];
   logic [MulW-1:0] ua, ub;
   logic [2*MulW-1:0] uprod_ff;
   logic [DiscW-1:0] bsq_ff, ac_ff;
   logic [3:0] lstep;
   assign lstep = 4'(step_ff);
   always_comb begin
      ua = '0;
      ub = '0;
      case (lstep)
         4'd0: begin ua = babs[35:0];  ub = babs[35:0]; end
         4'd1: begin ua = babs[35:0];  ub = MulW'(babs[ProdW:36]); end
         4'd2: begin ua = MulW'(babs[ProdW:36]); ub = MulW'(babs[ProdW:36]); end
         4'd3: begin ua = aabs[35:0];  ub = cabs[35:0]; end
         4'd4: begin ua = aabs[35:0];  ub = MulW'(cabs[ProdW+2:36]); end
         4'd5: begin ua = MulW'(aabs[ProdW-1:36]); ub = cabs[35:0]; end
         4'd6: begin ua = MulW'(aabs[ProdW-1:36]); ub = MulW'(cabs[ProdW+2:36]); end
         default: begin ua = '0; ub = '0; end
      endcase
   end

   // Square root and divide share the cell row.
   row_ctrl_type rctl;
   logic [RowW-1:0] rinit, rsub, rrem;
   logic [1:0] rfeed;
   logic rfits, rtwo;
   logic [RootW-1:0] root_ff;
   logic [DiscW-1:0] rad_ff;
   logic [NumW-1:0] num_ff;
   logic [QuoW+63:0] quo_ff;
   logic numneg_ff;
   logic rootsel_ff;

   rsch_row #(.W(RowW)) u_row (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (rctl),
      .init     (rinit),
      .feed     (rfeed),
      .two_bits (rtwo),
      .sub      (rsub),
      .rem      (rrem),
      .fits     (rfits)
   );

   logic signed [NumW-1:0] nb_ext, s_ext, numv;
   assign nb_ext = -NumW'(b_ff) <<< 1;
   assign s_ext  = NumW'({1'b0, root_ff});
   assign numv   = (rootsel_ff ? nb_ext - s_ext : nb_ext + s_ext) <<< 16;

   always_comb begin
      rctl = '0;
      rinit = '0;
      rfeed = '0;
      rtwo = 1'b0;
      rsub = '0;
      if (state_ff == SEQ_SQRT) begin
         rtwo = 1'b1;
         // first step takes the top bits straight from the discriminant
         rfeed = (step_ff == '0) ? disc_ff[DiscW-1 -: 2] : rad_ff[DiscW-1 -: 2];
         rsub = RowW'({root_ff, 2'b01});
         rctl.load = (step_ff == '0) && 1'b0;
         rctl.shift = 1'b1;
      end else if (state_ff == SEQ_DIV1 || state_ff == SEQ_DIV2) begin
         rfeed = {num_ff[NumW-1], 1'b0};
         rsub = RowW'({a_ff, 1'b0});
         rctl.load = (step_ff == '0);
         rctl.shift = (step_ff != '0);
      end else if (state_ff == SEQ_DISC) begin
         rctl.load = 1'b1;
      end
   end

   // Running best.
   logic found_ff, found_in;
   logic signed [ValW-1:0] best_ff;
   logic [SlotW-1:0] bslot_ff;
   logic signed [ValW-1:0] tq;
   logic [QuoW+63:0] qfin;
   logic signed [QuoW:0] qs;
   logic inexact;
   assign qfin = {quo_ff[QuoW+62:0], rfits};
   // after the last divide step the quotient and remainder sit in registers
   assign inexact = (rrem != '0);
   always_comb begin
      if (quo_ff[QuoW+63:QuoW] != '0) begin
         qs = numneg_ff ? SatLo : SatHi;
      end else if (numneg_ff) begin
         qs = -$signed({1'b0, quo_ff[QuoW-1:0]}) - (QuoW+1)'(inexact);
      end else begin
         qs = $signed({1'b0, quo_ff[QuoW-1:0]});
      end
      if (qs > SatHi) begin
         tq = ValW'(SatHi);
      end else if (qs < SatLo) begin
         tq = ValW'(SatLo);
      end else begin
         tq = ValW'(qs);
      end
   end

   logic cand_ok;
   assign cand_ok = ($signed(ValW'(lo_ff)) < tq) && (tq < $signed(ValW'(hi_ff)))
                    && (!found_ff || tq < best_ff);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff + 1'b1;
      case (state_ff)
         SEQ_IDLE: begin
            step_in = '0;
            if (accept && req_operation == OpCast) state_in = SEQ_NEXT;
         end
         SEQ_NEXT: begin
            step_in = '0;
            state_in = (slot_ff >= limit_ff) ? SEQ_DONE : SEQ_READ;
         end
         SEQ_READ: begin
            step_in = '0;
            state_in = SEQ_DOTS;
         end
         SEQ_DOTS: begin
            step_in = '0;
            if (mstep_ff == 4'd11) state_in = (a_ff == '0) ? SEQ_DONE : SEQ_DISC;
         end
         SEQ_DISC: begin
            if (step_ff == StepW'(9)) begin
               step_in = '0;
               state_in = disc_ff[DiscW-1] ? SEQ_NEXT : SEQ_SQRT;
            end
         end
         SEQ_SQRT: begin
            if (step_ff == StepW'(SqSteps - 1)) begin
               step_in = '0;
               state_in = SEQ_DIV1;
            end
         end
         SEQ_DIV1: begin
            if (step_ff == StepW'(DivSteps)) begin
               step_in = '0;
               state_in = SEQ_DIV2;
            end
         end
         SEQ_DIV2: begin
            if (step_ff == StepW'(DivSteps)) begin
               step_in = '0;
               state_in = SEQ_NEXT;
            end
         end
         SEQ_DONE: state_in = SEQ_IDLE;
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_comb begin
      busy = (state_ff != SEQ_IDLE);
      rsp_valid = (state_ff == SEQ_DONE);
      rsp_hit = found_ff;
      rsp_distance = found_ff ? best_ff : '0;
      rsp_sphere_index = found_ff ? bslot_ff : '0;
   end

   always_comb begin
      slot_in = slot_ff;
      if (state_ff == SEQ_IDLE) slot_in = '0;
      else if (state_in == SEQ_NEXT && state_ff != SEQ_NEXT && state_ff != SEQ_IDLE)
         slot_in = slot_ff + 1'b1;
      found_in = found_ff;
      if (state_ff == SEQ_IDLE) found_in = 1'b0;
      else if ((state_ff == SEQ_DIV1 || state_ff == SEQ_DIV2)
               && step_ff == StepW'(DivSteps) && cand_ok) found_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         count_ff <= '0;
         slot_ff  <= '0;
         found_ff <= 1'b0;
         step_ff  <= '0;
         mstep_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         slot_ff  <= slot_in;
         found_ff <= found_in;
         step_ff  <= step_in;
         mstep_ff <= (state_ff == SEQ_DOTS) ? mstep_ff + 1'b1 : 4'd0;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      prod_ff  <= ma * mb;
      uprod_ff <= ua * ub;
      if (state_ff == SEQ_READ) begin
         a_ff <= '0; b_ff <= '0; c_ff <= '0;
      end else if (state_ff == SEQ_DOTS) begin
         case (mstep_ff)
            4'd1, 4'd2, 4'd3: a_ff <= a_ff + ProdW'(prod_ff);
            4'd4, 4'd5, 4'd6: b_ff <= b_ff + ProdW'(prod_ff);
            4'd7, 4'd8, 4'd9: c_ff <= c_ff + ProdW'(prod_ff);
            4'd10: c_ff <= c_ff - ProdW'(prod_ff);
            default: ;
         endcase
      end
      if (state_ff == SEQ_DISC) begin
         case (lstep)
            4'd0: begin bsq_ff <= '0; ac_ff <= '0; end
            4'd1: bsq_ff <= bsq_ff + DiscW'(uprod_ff);
            4'd2: bsq_ff <= bsq_ff + (DiscW'(uprod_ff) << 37);
            4'd3: bsq_ff <= bsq_ff + (DiscW'(uprod_ff) << 72);
            4'd4: ac_ff <= ac_ff + DiscW'(uprod_ff);
            4'd5: ac_ff <= ac_ff + (DiscW'(uprod_ff) << 36);
            4'd6: ac_ff <= ac_ff + (DiscW'(uprod_ff) << 36);
            4'd7: ac_ff <= ac_ff + (DiscW'(uprod_ff) << 72);
            4'd8: disc_ff <= dneg ? bsq_ff + ac_ff : bsq_ff - ac_ff;
            default: ;
         endcase
         root_ff <= '0;
      end
      if (state_ff == SEQ_SQRT) begin
         rad_ff  <= (step_ff == '0) ? (disc_ff << 2) : (rad_ff << 2);
         root_ff <= {root_ff[RootW-2:0], rfits};
         rootsel_ff <= 1'b0;
      end
      if (state_ff == SEQ_DIV1 || state_ff == SEQ_DIV2) begin
         if (step_ff == '0) begin
            numneg_ff <= numv[NumW-1];
            num_ff <= numv[NumW-1] ? NumW'(0) - numv : numv;
            quo_ff <= '0;
         end else begin
            num_ff <= num_ff << 1;
            quo_ff <= qfin;
         end
         if (step_ff == StepW'(DivSteps)) begin
            rootsel_ff <= 1'b1;
            if (cand_ok) begin
               best_ff <= tq;
               bslot_ff <= SlotW'(slot_ff);
            end
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("result outside a transaction");
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == OpLoad) |=> !busy)
      else $error("load held the block");

endmodule

@@ test/tb_top.sv @@
// Testbench for ray_sphere_closest_hit: loads spheres, casts rays and checks each result
// against a wide-integer closest-hit predictor. Depends on rsch_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
   import rsch_pkg::*;

   typedef logic signed [255:0] wide_type;

   typedef struct {
      logic                   op;
      logic [SlotW-1:0]       slot;
      logic signed [ValW-1:0] px, py, pz;
      logic signed [ValW-1:0] dx, dy, dz;
      logic [RadW-1:0]        rad;
      logic signed [ValW-1:0] lo, hi;
   } ray_txn_type;

   typedef struct {
      logic                   hit;
      logic signed [ValW-1:0] distance;
      logic [SlotW-1:0]       idx;
   } hit_txn_type;

   localparam int unsigned CycleLimit = 10_000_000;
   localparam int One = 65536;

   class hit_scoreboard;
      logic signed [ValW-1:0] ctr_x [DefMaxSpheres];
      logic signed [ValW-1:0] ctr_y [DefMaxSpheres];
      logic signed [ValW-1:0] ctr_z [DefMaxSpheres];
      logic [RadW-1:0]        radius [DefMaxSpheres];
      int unsigned            slots_searched;
      hit_txn_type            hits_due[$];
      int                     errors;

      function void set_count(logic [CountW-1:0] v);
         slots_searched = v > DefMaxSpheres ? DefMaxSpheres : v;
      endfunction

      // floor(n / d) for d > 0, saturated to signed 32 bits
      function logic signed [ValW-1:0] floor_div_sat(wide_type n, wide_type d);
         wide_type q;
         q = n / d;
         if (n < 0 && (n % d) != 0) q = q - 1;
         if (q > wide_type'(32'sh7fffffff)) return 32'sh7fffffff;
         if (q < -wide_type'(64'sh80000000)) return 32'sh80000000;
         return q[ValW-1:0];
      endfunction

      function wide_type isqrt(wide_type x);
         wide_type res, cand;
         res = 0;
         for (int bit_pos = 79; bit_pos >= 0; bit_pos--) begin
            cand = res | (wide_type'(1) << bit_pos);
            if (cand * cand <= x) res = cand;
         end
         return res;
      endfunction

      function hit_txn_type closest_hit(ray_txn_type t);
         hit_txn_type r;
         wide_type co [3], dv [3], a, b, c, disc, s, den;
         logic signed [ValW-1:0] root [2];
         r = '{hit: 1'b0, distance: '0, idx: '0};
         dv[0] = wide_type'(t.dx); dv[1] = wide_type'(t.dy); dv[2] = wide_type'(t.dz);
         for (int k = 0; k < slots_searched; k++) begin
            co[0] = wide_type'(t.px) - wide_type'(ctr_x[k]);
            co[1] = wide_type'(t.py) - wide_type'(ctr_y[k]);
            co[2] = wide_type'(t.pz) - wide_type'(ctr_z[k]);
            a = 0; b = 0; c = 0;
            for (int i = 0; i < 3; i++) begin
               a = a + dv[i] * dv[i];
               b = b + co[i] * dv[i];
               c = c + co[i] * co[i];
            end
            // zero direction: no hit anywhere
            if (a == 0) return r;
            b = 2 * b;
            c = c - wide_type'({1'b0, radius[k]}) * wide_type'({1'b0, radius[k]});
            disc = b * b - 4 * a * c;
            if (disc < 0) continue;
            s = isqrt(disc);
            den = 2 * a;
            root[0] = floor_div_sat((s - b) * One, den);
            root[1] = floor_div_sat((-b - s) * One, den);
            for (int j = 0; j < 2; j++) begin
               if (t.lo < root[j] && root[j] < t.hi && (!r.hit || root[j] < r.distance))
               begin
                  r.hit = 1'b1;
                  r.distance = root[j];
                  r.idx = k[SlotW-1:0];
               end
            end
         end
         return r;
      endfunction

      function void note_accepted(ray_txn_type t);
         if (t.op == OpLoad) begin
            ctr_x[t.slot] = t.px;
            ctr_y[t.slot] = t.py;
            ctr_z[t.slot] = t.pz;
            radius[t.slot] = t.rad;
         end else begin
            hits_due.push_back(closest_hit(t));
         end
      endfunction

      function void check_result(logic hit, logic signed [ValW-1:0] distance,
                                 logic [SlotW-1:0] idx);
         hit_txn_type e;
         if (hits_due.size() == 0) begin
            $display("%0t: unexpected result hit=%0b distance=%h idx=%0d", $time, hit,
                     distance, idx);
            errors++;
            return;
         end
         e = hits_due.pop_front();
         if (hit !== e.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, e.hit, hit);
            errors++;
         end
         // distance is only defined on a hit
         if (e.hit && distance !== e.distance) begin
            $display("%0t: distance expected %h actual %h", $time, e.distance, distance);
            errors++;
         end
         if (idx !== e.idx) begin
            $display("%0t: sphere_index expected %0d actual %0d", $time, e.idx, idx);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_operation = 1'b0;
   logic [SlotW-1:0] req_sphere_slot = '0;
   logic signed [ValW-1:0] req_point_x = '0, req_point_y = '0, req_point_z = '0;
   logic signed [ValW-1:0] req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic [RadW-1:0] req_sphere_radius_in = '0;
   logic signed [ValW-1:0] req_window_low = '0, req_window_high = '0;
   logic rsp_valid, rsp_hit;
   logic signed [ValW-1:0] rsp_distance;
   logic [SlotW-1:0] rsp_sphere_index;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   hit_scoreboard sb;
   int unsigned cycles = 0;
   bit idling = 1'b1;

   ray_sphere_closest_hit uut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_hit, rsp_distance, rsp_sphere_index);
   end

   task automatic write_count(logic [CountW-1:0] v);
      @(posedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= CsrCount; pwdata <= 32'(v);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      sb.set_count(v);
   endtask

   task automatic send_txn(ray_txn_type t);
      int gap;
      gap = (idling && $urandom_range(0, 2) == 0) ? $urandom_range(1, 14) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= t.op; req_sphere_slot <= t.slot;
      req_point_x <= t.px; req_point_y <= t.py; req_point_z <= t.pz;
      req_dir_x <= t.dx; req_dir_y <= t.dy; req_dir_z <= t.dz;
      req_sphere_radius_in <= t.rad;
      req_window_low <= t.lo; req_window_high <= t.hi;
      do @(posedge clock); while (busy);
      sb.note_accepted(t);
   endtask

   // wait for every expected result, then let a trailing load finish
   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (sb.hits_due.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic signed [ValW-1:0] near_coord(int span);
      return ($urandom_range(0, 2 * span) - span) * One + $urandom_range(0, One - 1);
   endfunction

   function automatic ray_txn_type noise_txn();
      ray_txn_type t;
      t = '{op: 1'($urandom_range(0, 1)), slot: SlotW'($urandom), px: $urandom,
            py: $urandom, pz: $urandom, dx: $urandom, dy: $urandom, dz: $urandom,
            rad: RadW'($urandom), lo: $urandom, hi: $urandom};
      return t;
   endfunction

   function automatic ray_txn_type sphere_load(int unsigned max_slot);
      ray_txn_type t;
      t = noise_txn();
      t.op = OpLoad;
      t.slot = SlotW'($urandom_range(0, max_slot));
      t.px = near_coord(60); t.py = near_coord(60); t.pz = near_coord(60);
      t.rad = RadW'($urandom_range(1, 20) * One + $urandom_range(0, One - 1));
      return t;
   endfunction

   function automatic ray_txn_type ray_cast();
      ray_txn_type t;
      t = noise_txn();
      t.op = OpCast;
      t.px = near_coord(40); t.py = near_coord(40); t.pz = near_coord(40);
      if ($urandom_range(0, 19) == 0) begin
         t.dx = 0; t.dy = 0; t.dz = 0;
      end else begin
         t.dx = near_coord(3); t.dy = near_coord(3); t.dz = near_coord(3);
      end
      case ($urandom_range(0, 3))
         0: begin t.lo = 0; t.hi = 32'sh7fffffff; end
         1: begin t.lo = 32'sh80000000; t.hi = 32'sh7fffffff; end
         2: begin t.lo = -near_coord(20); t.hi = near_coord(100); end
         default: begin t.lo = near_coord(10); t.hi = t.lo + $urandom_range(1, 50) * One; end
      endcase
      return t;
   endfunction

   function automatic ray_txn_type mk(logic op, logic [SlotW-1:0] slot,
                                      int px, int py, int pz, int dx, int dy, int dz,
                                      int rad, int lo, int hi);
      ray_txn_type t;
      t = '{op: op, slot: slot, px: px, py: py, pz: pz, dx: dx, dy: dy, dz: dz,
            rad: rad[RadW-1:0], lo: lo, hi: hi};
      return t;
   endfunction

   initial begin
      ray_txn_type directed[$];
      int counts [] = '{0, 1, 3, 64, 5, 2, 127, 4, 6, 1, 3, 2, 5, 4, 1};
      int n_items;
      sb = new();
      sb.set_count(0);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the whole table so no cast reads an unwritten slot
      for (int k = 0; k < DefMaxSpheres; k++) begin
         ray_txn_type t;
         t = sphere_load(0);
         t.slot = SlotW'(k);
         send_txn(t);
      end
      drain();

      write_count(CountW'(2));
      // two identical spheres on the z axis: the lower slot wins the tie
      directed.push_back(mk(OpLoad, 0, 0, 0, 10*One, 0, 0, 0, 2*One, 0, 0));
      directed.push_back(mk(OpLoad, 1, 0, 0, 10*One, 0, 0, 0, 2*One, 0, 0));
      directed.push_back(mk(OpCast, 0, 0, 0, 0, 0, 0, One, 0, 0, 100*One));
      directed.push_back(mk(OpCast, 0, 0, 0, 0, 0, 0, 0, 0, 32'h80000000, 32'h7fffffff));
      directed.push_back(mk(OpCast, 0, 0, 0, 0, One, 0, 0, 0, 32'h80000000, 32'h7fffffff));
      directed.push_back(mk(OpCast, 0, 0, 0, 0, 0, 0, One, 0, 8*One, 12*One));
      directed.push_back(mk(OpCast, 0, 0, 0, 10*One, 0, 0, One, 0, -100*One, 100*One));
      directed.push_back(mk(OpCast, 0, 0, 0, 10*One, 0, 0, -One, 0, 0, 100*One));
      // tiny direction drives the roots into saturation
      directed.push_back(mk(OpCast, 0, 0, 0, 0, 0, 0, 1, 0, 32'h80000000, 32'h7fffffff));
      directed.push_back(mk(OpCast, 0, 0, 0, -30000*One, 0, 0, 1, 0, 0, 32'h7fffffff));
      directed.push_back(mk(OpCast, 63, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                            32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                            32'h80000000, 32'h7fffffff));
      directed.push_back(mk(OpCast, 0, 32'h80000000, 32'h80000000, 32'h80000000,
                            32'h80000000, 32'h80000000, 32'h80000000, 0,
                            32'h80000000, 32'h7fffffff));
      directed.push_back(mk(OpLoad, 1, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                            0, 0, 0, 32'h7fffffff, 0, 0));
      directed.push_back(mk(OpCast, 0, 0, 0, 0, One, One, One, 0, 32'h80000000, 32'h7fffffff));
      directed.push_back(mk(OpLoad, 63, 32'h80000000, 32'h80000000, 32'h80000000,
                            0, 0, 0, 0, 0, 0));
      directed.push_back(mk(OpCast, 0, 0, 0, 0, -One, -One, -One, 0,
                            32'h80000000, 32'h7fffffff));
      foreach (directed[i]) send_txn(directed[i]);
      drain();

      foreach (counts[p]) begin
         write_count(CountW'(counts[p]));
         n_items = counts[p] >= DefMaxSpheres ? 4 : 100;
         if (p == counts.size() - 1) idling = 1'b0;
         for (int i = 0; i < n_items; i++) begin
            int unsigned pick;
            int unsigned top;
            pick = $urandom_range(0, 9);
            top = counts[p] == 0 ? 0 : (counts[p] > DefMaxSpheres ? DefMaxSpheres : counts[p]) - 1;
            if (pick == 0) send_txn(noise_txn());
            else if (pick <= 3) send_txn(sphere_load(top));
            else send_txn(ray_cast());
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.hits_due.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
